// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/spsq_pkg.sv
// ----------------------------------------------------------------------------
// spsq_pkg
// shared types, codes and reset values of the slalom pass sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package spsq_pkg;

    localparam int PIXEL_BITS_DEF = 12;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;
    localparam int SERIAL_STEPS   = 16;

    localparam logic [2:0] REG_IMAGE_SIZE      = 3'd0;
    localparam logic [2:0] REG_SETS_TO_PASS    = 3'd1;
    localparam logic [2:0] REG_COMMIT_FRACTION = 3'd2;
    localparam logic [2:0] REG_COAST_TIME_MS   = 3'd3;
    localparam logic [2:0] REG_APPROACH_THRUST = 3'd4;
    localparam logic [2:0] REG_COAST_THRUST    = 3'd5;
    localparam logic [2:0] REG_SWAY_GAIN_Q     = 3'd6;
    localparam logic [2:0] REG_SIDE_OFFSET     = 3'd7;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_BOX   = 2'd2;

    localparam logic [2:0] PH_HOLD   = 3'd0;
    localparam logic [2:0] PH_COAST  = 3'd1;
    localparam logic [2:0] PH_SEARCH = 3'd2;
    localparam logic [2:0] PH_TRACK  = 3'd3;
    localparam logic [2:0] PH_FINISH = 3'd4;

    localparam logic [7:0]  RST_SETS_TO_PASS    = 8'd3;
    localparam logic [15:0] RST_COMMIT_FRACTION = 16'd13107;
    localparam logic [15:0] RST_COAST_TIME_MS   = 16'd6000;
    localparam logic [15:0] RST_APPROACH_THRUST = 16'd1280;
    localparam logic [15:0] RST_COAST_THRUST    = 16'd3840;
    localparam logic [15:0] RST_SWAY_GAIN_Q     = 16'd3840;
    localparam logic [15:0] RST_SIDE_OFFSET     = 16'd13107;

    typedef struct packed {
        logic [7:0]  sets_to_pass;
        logic [15:0] commit_fraction;
        logic [15:0] coast_time_ms;
        logic [15:0] approach_thrust;
        logic [15:0] coast_thrust;
        logic [15:0] sway_gain_q;
        logic [15:0] side_offset;
    } spsq_cfg_t;

endpackage

`default_nettype wire

// File: rtl/spsq_alu.sv
// ----------------------------------------------------------------------------
// spsq_alu
// shared adder with carry out and small signed multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module spsq_alu #(
    parameter int PIXEL_BITS = spsq_pkg::PIXEL_BITS_DEF
) (
    input  wire logic [PIXEL_BITS+36:0] a,
    input  wire logic [PIXEL_BITS+36:0] b,
    input  wire logic                   cin,
    output logic      [PIXEL_BITS+36:0] sum,
    output logic                        cout,
    input  wire logic [16:0]            mul_a,
    input  wire logic [PIXEL_BITS:0]    mul_b,
    output logic      [PIXEL_BITS+17:0] mul_p
);

    localparam int AW = PIXEL_BITS + 37;
    localparam int MW = PIXEL_BITS + 18;

    logic signed [MW-1:0] mul_a_x;
    logic signed [MW-1:0] mul_b_x;

    assign {cout, sum} = {1'b0, a} + {1'b0, b} + {{AW{1'b0}}, cin};

    assign mul_a_x = $signed({{(MW-17){mul_a[16]}}, mul_a});
    assign mul_b_x = $signed({{(MW-PIXEL_BITS-1){mul_b[PIXEL_BITS]}}, mul_b});
    assign mul_p   = mul_a_x * mul_b_x;

endmodule

`default_nettype wire

// File: rtl/spsq_regs.sv
// ----------------------------------------------------------------------------
// spsq_regs
// configuration register file behind the apb port
// ----------------------------------------------------------------------------
`default_nettype none

module spsq_regs #(
    parameter int PIXEL_BITS = spsq_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [spsq_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [spsq_pkg::DATA_W-1:0]     pwdata,
    output logic      [spsq_pkg::DATA_W-1:0]     prdata,
    output logic                                 pready,
    output logic      [PIXEL_BITS-1:0]           img_w,
    output logic      [PIXEL_BITS-1:0]           img_h,
    output spsq_pkg::spsq_cfg_t                  cfg
);

    logic [2*PIXEL_BITS-1:0] image_size_reg;
    spsq_pkg::spsq_cfg_t     cfg_reg;
    logic [2:0]              index;
    logic                    wr_en;

    assign index  = paddr[spsq_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign img_w  = image_size_reg[PIXEL_BITS-1:0];
    assign img_h  = image_size_reg[2*PIXEL_BITS-1:PIXEL_BITS];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg          <= '0;
            cfg_reg.sets_to_pass    <= spsq_pkg::RST_SETS_TO_PASS;
            cfg_reg.commit_fraction <= spsq_pkg::RST_COMMIT_FRACTION;
            cfg_reg.coast_time_ms   <= spsq_pkg::RST_COAST_TIME_MS;
            cfg_reg.approach_thrust <= spsq_pkg::RST_APPROACH_THRUST;
            cfg_reg.coast_thrust    <= spsq_pkg::RST_COAST_THRUST;
            cfg_reg.sway_gain_q     <= spsq_pkg::RST_SWAY_GAIN_Q;
            cfg_reg.side_offset     <= spsq_pkg::RST_SIDE_OFFSET;
        end
        else if (wr_en)
        begin
            unique case (index)
                spsq_pkg::REG_IMAGE_SIZE:      image_size_reg <= pwdata[2*PIXEL_BITS-1:0];
                spsq_pkg::REG_SETS_TO_PASS:    cfg_reg.sets_to_pass <= pwdata[7:0];
                spsq_pkg::REG_COMMIT_FRACTION: cfg_reg.commit_fraction <= pwdata[15:0];
                spsq_pkg::REG_COAST_TIME_MS:   cfg_reg.coast_time_ms <= pwdata[15:0];
                spsq_pkg::REG_APPROACH_THRUST: cfg_reg.approach_thrust <= pwdata[15:0];
                spsq_pkg::REG_COAST_THRUST:    cfg_reg.coast_thrust <= pwdata[15:0];
                spsq_pkg::REG_SWAY_GAIN_Q:     cfg_reg.sway_gain_q <= pwdata[15:0];
                spsq_pkg::REG_SIDE_OFFSET:     cfg_reg.side_offset <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            spsq_pkg::REG_IMAGE_SIZE:      prdata = spsq_pkg::DATA_W'(image_size_reg);
            spsq_pkg::REG_SETS_TO_PASS:    prdata = spsq_pkg::DATA_W'(cfg_reg.sets_to_pass);
            spsq_pkg::REG_COMMIT_FRACTION: prdata = spsq_pkg::DATA_W'(cfg_reg.commit_fraction);
            spsq_pkg::REG_COAST_TIME_MS:   prdata = spsq_pkg::DATA_W'(cfg_reg.coast_time_ms);
            spsq_pkg::REG_APPROACH_THRUST: prdata = spsq_pkg::DATA_W'(cfg_reg.approach_thrust);
            spsq_pkg::REG_COAST_THRUST:    prdata = spsq_pkg::DATA_W'(cfg_reg.coast_thrust);
            spsq_pkg::REG_SWAY_GAIN_Q:     prdata = spsq_pkg::DATA_W'(cfg_reg.sway_gain_q);
            spsq_pkg::REG_SIDE_OFFSET:     prdata = spsq_pkg::DATA_W'(cfg_reg.side_offset);
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/slalom_pass_sequencer.sv
// ----------------------------------------------------------------------------
// slalom_pass_sequencer: pipe tracking and slalom mission sequencer
// frame and box transfers finish in idle; hold and search ticks go straight to emit; coast ticks pass cel and cto
// a tracking tick runs on the shared adder, with no divide steps when the sway saturates:
// 16 multiply steps, 16 divide steps; a stalled result holds the next result back
// async reset clears mission state and loads config defaults; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module slalom_pass_sequencer #(
    parameter int PIXEL_BITS = spsq_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  kind,
    input  wire logic                        label_match,
    input  wire logic [PIXEL_BITS-1:0]       box_left,
    input  wire logic [PIXEL_BITS-1:0]       box_width,
    input  wire logic [PIXEL_BITS-1:0]       box_height,
    input  wire logic [31:0]                 now_ms,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [15:0]               thrust_x,
    output logic signed [15:0]               thrust_y,
    output logic [2:0]                       phase,
    output logic                             success,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [spsq_pkg::ADDR_W-1:0] paddr,
    input  wire logic [spsq_pkg::DATA_W-1:0] pwdata,
    output logic      [spsq_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);

    localparam int P  = PIXEL_BITS;
    localparam int AW = P + 37;
    localparam int MW = P + 18;
    localparam int EW = P + 3;
    localparam int CW = $clog2(spsq_pkg::SERIAL_STEPS);
    localparam logic [CW-1:0] LAST_STEP = CW'(spsq_pkg::SERIAL_STEPS - 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CEL  = 4'd1;
    localparam logic [3:0] ST_CTO  = 4'd2;
    localparam logic [3:0] ST_KMUL = 4'd3;
    localparam logic [3:0] ST_KCMP = 4'd4;
    localparam logic [3:0] ST_SMUL = 4'd5;
    localparam logic [3:0] ST_TSUB = 4'd6;
    localparam logic [3:0] ST_TABS = 4'd7;
    localparam logic [3:0] ST_MUL  = 4'd8;
    localparam logic [3:0] ST_BIAS = 4'd9;
    localparam logic [3:0] ST_SAT  = 4'd10;
    localparam logic [3:0] ST_DIV  = 4'd11;
    localparam logic [3:0] ST_FIN  = 4'd12;
    localparam logic [3:0] ST_EMIT = 4'd13;

    spsq_pkg::spsq_cfg_t cfg;
    logic [P-1:0]        img_w;
    logic [P-1:0]        img_h;

    logic [AW-1:0]       alu_a;
    logic [AW-1:0]       alu_b;
    logic                alu_cin;
    logic [AW-1:0]       alu_sum;
    logic                alu_cout;
    logic [16:0]         mul_a;
    logic [P:0]          mul_b;
    logic [MW-1:0]       mul_p;

    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [31:0]         now_reg, now_next;
    logic [AW-1:0]       acc_reg, acc_next;
    logic [MW-1:0]       prod_reg, prod_next;
    logic [AW-1:0]       mcand_reg, mcand_next;
    logic [15:0]         gbits_reg, gbits_next;
    logic                neg_reg, neg_next;
    logic                big_reg, big_next;
    logic [P-1:0]        rem_reg, rem_next;
    logic [15:0]         q_reg, q_next;
    logic signed [15:0]  res_tx_reg, res_tx_next;
    logic signed [15:0]  res_ty_reg, res_ty_next;
    logic [2:0]          res_ph_reg, res_ph_next;
    logic                res_ok_reg, res_ok_next;

    logic                seen_reg, seen_next;
    logic [P-1:0]        best_left_reg, best_left_next;
    logic [P-1:0]        best_width_reg, best_width_next;
    logic [P-1:0]        best_height_reg, best_height_next;
    logic                committed_reg, committed_next;
    logic                coasting_reg, coasting_next;
    logic [31:0]         coast_start_reg, coast_start_next;
    logic [7:0]          sets_done_reg, sets_done_next;
    logic                finished_reg, finished_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_load;
    logic signed [15:0]  out_tx_reg;
    logic signed [15:0]  out_ty_reg;
    logic [2:0]          out_ph_reg;
    logic                out_ok_reg;

    logic signed [EW-1:0] err;
    logic [AW-1:0]        err_sh;
    logic [7:0]           sets_inc;
    logic [P:0]           trial;
    logic [15:0]          mag;
    logic [15:0]          ty_sat;

    spsq_regs #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .img_w   (img_w),
        .img_h   (img_h),
        .cfg     (cfg)
    );

    spsq_alu #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .cin   (alu_cin),
        .sum   (alu_sum),
        .cout  (alu_cout),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign thrust_x  = out_tx_reg;
    assign thrust_y  = out_ty_reg;
    assign phase     = out_ph_reg;
    assign success   = out_ok_reg;

    // centre error 2L + w - W, scaled by 2^15
    assign err = $signed({2'b00, best_left_reg, 1'b0}) + $signed({3'b000, best_width_reg})
               - $signed({3'b000, img_w});
    assign err_sh   = {{(AW-EW-15){err[EW-1]}}, err, 15'b0};
    assign sets_inc = (sets_done_reg != 8'hFF) ? sets_done_reg + 8'd1 : sets_done_reg;
    assign trial    = {rem_reg, q_reg[15]};

    always_comb
    begin
        mag = big_reg ? 16'hFFFF : q_reg;
        if (neg_reg)
        begin
            ty_sat = (mag > 16'd32768) ? 16'h8000 : 16'd0 - mag;
        end
        else
        begin
            ty_sat = (mag > 16'd32767) ? 16'h7FFF : mag;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        now_next         = now_reg;
        acc_next         = acc_reg;
        prod_next        = prod_reg;
        mcand_next       = mcand_reg;
        gbits_next       = gbits_reg;
        neg_next         = neg_reg;
        big_next         = big_reg;
        rem_next         = rem_reg;
        q_next           = q_reg;
        res_tx_next      = res_tx_reg;
        res_ty_next      = res_ty_reg;
        res_ph_next      = res_ph_reg;
        res_ok_next      = res_ok_reg;
        seen_next        = seen_reg;
        best_left_next   = best_left_reg;
        best_width_next  = best_width_reg;
        best_height_next = best_height_reg;
        committed_next   = committed_reg;
        coasting_next    = coasting_reg;
        coast_start_next = coast_start_reg;
        sets_done_next   = sets_done_reg;
        finished_next    = finished_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_load         = 1'b0;
        alu_a            = '0;
        alu_b            = '0;
        alu_cin          = 1'b0;
        mul_a            = '0;
        mul_b            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind)
                        spsq_pkg::KIND_CLEAR:
                        begin
                            seen_next = 1'b0;
                        end
                        spsq_pkg::KIND_BOX:
                        begin
                            if (label_match && (!seen_reg || box_height > best_height_reg))
                            begin
                                seen_next        = 1'b1;
                                best_left_next   = box_left;
                                best_width_next  = box_width;
                                best_height_next = box_height;
                            end
                        end
                        spsq_pkg::KIND_TICK:
                        begin
                            now_next = now_ms;
                            if (!finished_reg)
                            begin
                                if (img_w == '0 || img_h == '0)
                                begin
                                    res_tx_next = '0;
                                    res_ty_next = '0;
                                    res_ph_next = spsq_pkg::PH_HOLD;
                                    res_ok_next = 1'b0;
                                    state_next  = ST_EMIT;
                                end
                                else if (coasting_reg)
                                begin
                                    state_next = ST_CEL;
                                end
                                else if (!seen_reg)
                                begin
                                    if (committed_reg)
                                    begin
                                        coasting_next    = 1'b1;
                                        coast_start_next = now_ms;
                                    end
                                    else
                                    begin
                                        res_tx_next = $signed(cfg.approach_thrust);
                                        res_ty_next = '0;
                                        res_ph_next = spsq_pkg::PH_SEARCH;
                                        res_ok_next = 1'b0;
                                        state_next  = ST_EMIT;
                                    end
                                end
                                else
                                begin
                                    state_next = ST_KMUL;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CEL:
            begin
                // elapsed time modulo 2^32
                alu_a      = AW'(now_reg);
                alu_b      = ~AW'(coast_start_reg);
                alu_cin    = 1'b1;
                acc_next   = alu_sum;
                state_next = ST_CTO;
            end
            ST_CTO:
            begin
                alu_a   = AW'(acc_reg[31:0]);
                alu_b   = ~AW'(cfg.coast_time_ms);
                alu_cin = 1'b1;
                if (!alu_cout)
                begin
                    res_tx_next = $signed(cfg.coast_thrust);
                    res_ty_next = '0;
                    res_ph_next = spsq_pkg::PH_COAST;
                    res_ok_next = 1'b0;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    sets_done_next = sets_inc;
                    coasting_next  = 1'b0;
                    committed_next = 1'b0;
                    if (sets_inc >= cfg.sets_to_pass)
                    begin
                        finished_next = 1'b1;
                        res_tx_next   = '0;
                        res_ty_next   = '0;
                        res_ph_next   = spsq_pkg::PH_FINISH;
                        res_ok_next   = 1'b1;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_KMUL:
            begin
                mul_a      = {1'b0, cfg.commit_fraction};
                mul_b      = {1'b0, img_h};
                prod_next  = mul_p;
                state_next = ST_KCMP;
            end
            ST_KCMP:
            begin
                alu_a   = AW'({best_height_reg, 15'b0});
                alu_b   = ~AW'(prod_reg);
                alu_cin = 1'b1;
                if (!committed_reg && alu_cout)
                begin
                    committed_next = 1'b1;
                end
                state_next = ST_SMUL;
            end
            ST_SMUL:
            begin
                mul_a      = {cfg.side_offset[15], cfg.side_offset};
                mul_b      = {1'b0, img_w};
                prod_next  = mul_p;
                state_next = ST_TSUB;
            end
            ST_TSUB:
            begin
                alu_a      = {{(AW-MW){prod_reg[MW-1]}}, prod_reg};
                alu_b      = ~err_sh;
                alu_cin    = 1'b1;
                acc_next   = alu_sum;
                neg_next   = alu_sum[AW-1];
                state_next = ST_TABS;
            end
            ST_TABS:
            begin
                alu_a      = '0;
                alu_b      = ~acc_reg;
                alu_cin    = 1'b1;
                mcand_next = neg_reg ? alu_sum : acc_reg;
                acc_next   = '0;
                gbits_next = cfg.sway_gain_q;
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // shift-add of gain times error magnitude
                alu_a      = acc_reg;
                alu_b      = gbits_reg[0] ? mcand_reg : '0;
                acc_next   = alu_sum;
                mcand_next = {mcand_reg[AW-2:0], 1'b0};
                gbits_next = {1'b0, gbits_reg[15:1]};
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_BIAS;
                end
            end
            ST_BIAS:
            begin
                // half the divisor for round to nearest
                alu_a      = acc_reg;
                alu_b      = AW'({img_w, 14'b0});
                acc_next   = alu_sum;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                alu_a    = AW'(acc_reg[AW-1:15]);
                alu_b    = ~AW'({img_w, 16'b0});
                alu_cin  = 1'b1;
                big_next = alu_cout;
                rem_next = acc_reg[31 +: P];
                q_next   = acc_reg[30:15];
                cnt_next = '0;
                state_next = alu_cout ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                alu_a    = AW'(trial);
                alu_b    = ~AW'(img_w);
                alu_cin  = 1'b1;
                rem_next = alu_cout ? alu_sum[P-1:0] : trial[P-1:0];
                q_next   = {q_reg[14:0], alu_cout};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                res_tx_next = $signed(cfg.approach_thrust);
                res_ty_next = $signed(ty_sat);
                res_ph_next = spsq_pkg::PH_TRACK;
                res_ok_next = 1'b0;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            seen_reg        <= 1'b0;
            committed_reg   <= 1'b0;
            coasting_reg    <= 1'b0;
            coast_start_reg <= '0;
            sets_done_reg   <= '0;
            finished_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            seen_reg        <= seen_next;
            committed_reg   <= committed_next;
            coasting_reg    <= coasting_next;
            coast_start_reg <= coast_start_next;
            sets_done_reg   <= sets_done_next;
            finished_reg    <= finished_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        acc_reg         <= acc_next;
        prod_reg        <= prod_next;
        mcand_reg       <= mcand_next;
        gbits_reg       <= gbits_next;
        neg_reg         <= neg_next;
        big_reg         <= big_next;
        rem_reg         <= rem_next;
        q_reg           <= q_next;
        res_tx_reg      <= res_tx_next;
        res_ty_reg      <= res_ty_next;
        res_ph_reg      <= res_ph_next;
        res_ok_reg      <= res_ok_next;
        best_left_reg   <= best_left_next;
        best_width_reg  <= best_width_next;
        best_height_reg <= best_height_next;
        if (out_load)
        begin
            out_tx_reg <= res_tx_reg;
            out_ty_reg <= res_ty_reg;
            out_ph_reg <= res_ph_reg;
            out_ok_reg <= res_ok_reg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/spsq_checker.sv
// ----------------------------------------------------------------------------
// spsq_checker
// port level checks of the slalom pass sequencer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spsq_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic [1:0]        kind,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic signed [15:0] thrust_x,
    input wire logic signed [15:0] thrust_y,
    input wire logic [2:0]        phase,
    input wire logic              success
);

    // a stalled result transfer holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(thrust_x) && $stable(thrust_y) && $stable(phase) && $stable(success))

    // success only comes with the finished stop
    `ASSERT_IMPLIES(a_success_finish, clk, rst_n, out_valid, success == (phase == spsq_pkg::PH_FINISH))

    // sway force only while tracking
    `ASSERT_IMPLIES(a_sway_track, clk, rst_n, out_valid && phase != spsq_pkg::PH_TRACK, thrust_y == 16'sd0)

    // no forward force while holding
    `ASSERT_IMPLIES(a_hold_stop, clk, rst_n, out_valid && phase == spsq_pkg::PH_HOLD, thrust_x == 16'sd0)

    // box and clear transfers keep the block ready
    `ASSERT_NEXT(a_box_ready, clk, rst_n, in_valid && !in_stall && (kind == spsq_pkg::KIND_BOX || kind == spsq_pkg::KIND_CLEAR), !in_stall)

endmodule

bind slalom_pass_sequencer spsq_checker u_spsq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .thrust_x  (thrust_x),
    .thrust_y  (thrust_y),
    .phase     (phase),
    .success   (success)
);

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: slalom pass sequencer testbench
// drives detection frames, boxes and control ticks over the valid/stall input,
// programs the registers over apb while idle, and compares every command
// transfer against a local mission model in order of arrival
// ----------------------------------------------------------------------------

module tb_top;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 60;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic        label_match;
        logic [11:0] box_left;
        logic [11:0] box_width;
        logic [11:0] box_height;
        logic [31:0] now_ms;
    } sensor_item_t;

    typedef struct {
        logic signed [15:0] thrust_x;
        logic signed [15:0] thrust_y;
        logic [2:0]         phase;
        logic               success;
    } force_cmd_t;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [1:0]          kind        = spsq_pkg::KIND_TICK;
    logic                label_match = 1'b0;
    logic [11:0]         box_left    = '0;
    logic [11:0]         box_width   = '0;
    logic [11:0]         box_height  = '0;
    logic [31:0]         now_ms      = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic signed [15:0]  thrust_x;
    logic signed [15:0]  thrust_y;
    logic [2:0]          phase;
    logic                success;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [spsq_pkg::ADDR_W-1:0] paddr  = '0;
    logic [spsq_pkg::DATA_W-1:0] pwdata = '0;
    logic [spsq_pkg::DATA_W-1:0] prdata;
    logic                pready;

    // register copies
    logic [23:0]         cfg_image_size;
    logic [7:0]          cfg_sets;
    logic [15:0]         cfg_commit;
    logic [15:0]         cfg_coast_ms;
    logic signed [15:0]  cfg_approach;
    logic signed [15:0]  cfg_coast_thr;
    logic [15:0]         cfg_gain;
    logic signed [15:0]  cfg_side;

    // mission state copies
    logic                ms_seen;
    logic [11:0]         ms_best_l;
    logic [11:0]         ms_best_w;
    logic [11:0]         ms_best_h;
    logic                ms_committed;
    logic                ms_coasting;
    logic [31:0]         ms_coast_t0;
    logic [7:0]          ms_sets_done;
    logic                ms_finished;

    force_cmd_t          pending_cmds[$];
    force_cmd_t          head_cmd;
    int                  mismatch_count = 0;
    int                  send_idle_pct  = 0;
    int                  recv_idle_pct  = 0;
    bit                  hold_req       = 0;
    int                  hold_left      = 0;
    int                  quiet_cycles   = 0;
    logic [31:0]         cur_ms;

    slalom_pass_sequencer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .label_match (label_match),
        .box_left    (box_left),
        .box_width   (box_width),
        .box_height  (box_height),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .thrust_x    (thrust_x),
        .thrust_y    (thrust_y),
        .phase       (phase),
        .success     (success),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // mission model
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] sway_cmd(input logic [11:0] img_w);
        longint w;
        longint err;
        longint num;
        longint den;
        longint mag;
        bit     neg;
        w   = longint'(img_w);
        err = 2 * longint'(ms_best_l) + longint'(ms_best_w) - w;
        num = longint'(cfg_gain) * (longint'(cfg_side) * w - err * 32768);
        den = 32768 * w;
        neg = num < 0;
        mag = neg ? -num : num;
        mag = (mag + den / 2) / den;
        if (neg)
        begin
            if (mag > 32768)
                mag = 32768;
            return 16'(-mag);
        end
        if (mag > 32767)
            mag = 32767;
        return 16'(mag);
    endfunction

    function automatic bit advance_mission(input sensor_item_t it, output force_cmd_t cmd);
        logic [11:0] img_w;
        logic [11:0] img_h;
        logic [31:0] elapsed;
        cmd   = '{thrust_x: '0, thrust_y: '0, phase: spsq_pkg::PH_HOLD, success: 1'b0};
        img_w = cfg_image_size[11:0];
        img_h = cfg_image_size[23:12];
        if (it.kind == spsq_pkg::KIND_CLEAR)
        begin
            ms_seen = 1'b0;
            return 0;
        end
        if (it.kind == spsq_pkg::KIND_BOX)
        begin
            if (it.label_match && (!ms_seen || it.box_height > ms_best_h))
            begin
                ms_seen   = 1'b1;
                ms_best_l = it.box_left;
                ms_best_w = it.box_width;
                ms_best_h = it.box_height;
            end
            return 0;
        end
        if (it.kind != spsq_pkg::KIND_TICK)
            return 0;
        if (ms_finished)
            return 0;
        if (img_w == 0 || img_h == 0)
            return 1;
        if (ms_coasting)
        begin
            elapsed = it.now_ms - ms_coast_t0;
            if (elapsed < {16'd0, cfg_coast_ms})
            begin
                cmd.thrust_x = cfg_coast_thr;
                cmd.phase    = spsq_pkg::PH_COAST;
                return 1;
            end
            if (ms_sets_done != 8'd255)
                ms_sets_done = ms_sets_done + 8'd1;
            ms_coasting  = 1'b0;
            ms_committed = 1'b0;
            if (ms_sets_done >= cfg_sets)
            begin
                ms_finished = 1'b1;
                cmd.phase   = spsq_pkg::PH_FINISH;
                cmd.success = 1'b1;
                return 1;
            end
            return 0;
        end
        if (!ms_seen)
        begin
            if (ms_committed)
            begin
                ms_coasting = 1'b1;
                ms_coast_t0 = it.now_ms;
                return 0;
            end
            cmd.thrust_x = cfg_approach;
            cmd.phase    = spsq_pkg::PH_SEARCH;
            return 1;
        end
        if (!ms_committed &&
            longint'(ms_best_h) * 32768 >= longint'(cfg_commit) * longint'(img_h))
            ms_committed = 1'b1;
        cmd.thrust_x = cfg_approach;
        cmd.thrust_y = sway_cmd(img_w);
        cmd.phase    = spsq_pkg::PH_TRACK;
        return 1;
    endfunction

    // ------------------------------------------------------------------
    // command checker and receiver stall
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_cmds.size() == 0)
            begin
                $error("unexpected command: thrust_x %0d thrust_y %0d phase %0d success %0d",
                       thrust_x, thrust_y, phase, success);
                mismatch_count++;
            end
            else
            begin
                head_cmd = pending_cmds.pop_front();
                if (thrust_x !== head_cmd.thrust_x)
                begin
                    $error("thrust_x expected %0d actual %0d", head_cmd.thrust_x, thrust_x);
                    mismatch_count++;
                end
                if (thrust_y !== head_cmd.thrust_y)
                begin
                    $error("thrust_y expected %0d actual %0d", head_cmd.thrust_y, thrust_y);
                    mismatch_count++;
                end
                if (phase !== head_cmd.phase)
                begin
                    $error("phase expected %0d actual %0d", head_cmd.phase, phase);
                    mismatch_count++;
                end
                if (success !== head_cmd.success)
                begin
                    $error("success expected %0d actual %0d", head_cmd.success, success);
                    mismatch_count++;
                end
            end
        end
        if (hold_req)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // transfer helpers
    // ------------------------------------------------------------------
    task automatic send_transfer(input sensor_item_t it);
        force_cmd_t cmd;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= it.kind;
        label_match <= it.label_match;
        box_left    <= it.box_left;
        box_width   <= it.box_width;
        box_height  <= it.box_height;
        now_ms      <= it.now_ms;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (advance_mission(it, cmd))
            pending_cmds.push_back(cmd);
    endtask

    function automatic sensor_item_t random_item(input logic [1:0] k);
        sensor_item_t it;
        it.kind        = k;
        it.label_match = 1'($urandom);
        it.box_left    = 12'($urandom);
        it.box_width   = 12'($urandom);
        it.box_height  = 12'($urandom);
        it.now_ms      = $urandom;
        return it;
    endfunction

    task automatic send_tick(input logic [31:0] t);
        sensor_item_t it;
        it        = random_item(spsq_pkg::KIND_TICK);
        it.now_ms = t;
        send_transfer(it);
    endtask

    task automatic send_clear();
        send_transfer(random_item(spsq_pkg::KIND_CLEAR));
    endtask

    task automatic send_box(input logic lm, input logic [11:0] l, input logic [11:0] w,
                            input logic [11:0] h);
        sensor_item_t it;
        it             = random_item(spsq_pkg::KIND_BOX);
        it.label_match = lm;
        it.box_left    = l;
        it.box_width   = w;
        it.box_height  = h;
        send_transfer(it);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            spsq_pkg::REG_IMAGE_SIZE:      cfg_image_size = val[23:0];
            spsq_pkg::REG_SETS_TO_PASS:    cfg_sets       = val[7:0];
            spsq_pkg::REG_COMMIT_FRACTION: cfg_commit     = val[15:0];
            spsq_pkg::REG_COAST_TIME_MS:   cfg_coast_ms   = val[15:0];
            spsq_pkg::REG_APPROACH_THRUST: cfg_approach   = val[15:0];
            spsq_pkg::REG_COAST_THRUST:    cfg_coast_thr  = val[15:0];
            spsq_pkg::REG_SWAY_GAIN_Q:     cfg_gain       = val[15:0];
            spsq_pkg::REG_SIDE_OFFSET:     cfg_side       = val[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_settings(input logic [23:0] img, input logic [7:0] sets,
                                  input logic [15:0] commit, input logic [15:0] coast_ms,
                                  input logic [15:0] appr, input logic [15:0] coast_thr,
                                  input logic [15:0] gain, input logic [15:0] side);
        set_reg(spsq_pkg::REG_IMAGE_SIZE, {8'd0, img});
        set_reg(spsq_pkg::REG_SETS_TO_PASS, {24'd0, sets});
        set_reg(spsq_pkg::REG_COMMIT_FRACTION, {16'd0, commit});
        set_reg(spsq_pkg::REG_COAST_TIME_MS, {16'd0, coast_ms});
        set_reg(spsq_pkg::REG_APPROACH_THRUST, {16'd0, appr});
        set_reg(spsq_pkg::REG_COAST_THRUST, {16'd0, coast_thr});
        set_reg(spsq_pkg::REG_SWAY_GAIN_Q, {16'd0, gain});
        set_reg(spsq_pkg::REG_SIDE_OFFSET, {16'd0, side});
    endtask

    function automatic logic [11:0] clamp_pix(input int v);
        if (v < 0)
            return 12'd0;
        if (v > 4095)
            return 12'd4095;
        return 12'(v);
    endfunction

    function automatic logic [7:0] sets_ahead(input int extra);
        int s;
        s = int'(ms_sets_done) + extra;
        return (s > 255) ? 8'd255 : 8'(s);
    endfunction

    // one committed pass: commit, lose the pipe, coast, time out
    task automatic run_pass();
        logic [31:0] t0;
        send_clear();
        send_box(1'b1, 12'd100, 12'd200, 12'd4095);
        cur_ms = cur_ms + 32'd100;
        send_tick(cur_ms);
        send_clear();
        cur_ms = cur_ms + 32'd100;
        t0     = cur_ms;
        send_tick(t0);
        send_tick(t0 + 32'd1);
        cur_ms = t0 + {16'd0, cfg_coast_ms};
        send_tick(cur_ms);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_hold_on_unknown_image();
        send_tick(cur_ms);
        send_transfer(random_item(KIND_SPARE));
        drain_results();
        set_reg(spsq_pkg::REG_IMAGE_SIZE, {8'd0, 12'd0, 12'd640});
        send_tick(cur_ms);
        drain_results();
        set_reg(spsq_pkg::REG_IMAGE_SIZE, {8'd0, 12'd480, 12'd0});
        send_tick(cur_ms);
        drain_results();
        set_reg(spsq_pkg::REG_IMAGE_SIZE, {8'd0, 12'd480, 12'd640});
    endtask

    task automatic test_box_selection();
        send_tick(cur_ms);
        send_clear();
        send_box(1'b0, 12'd10, 12'd20, 12'd4095);
        send_box(1'b1, 12'd100, 12'd50, 12'd40);
        send_box(1'b1, 12'd300, 12'd60, 12'd40);
        send_box(1'b1, 12'd0, 12'd0, 12'd10);
        send_tick(cur_ms + 32'd10);
        send_clear();
        send_box(1'b1, 12'd0, 12'd0, 12'd0);
        send_tick(cur_ms + 32'd20);
        send_clear();
        send_box(1'b1, 12'd4095, 12'd4095, 12'd4095);
        cur_ms = cur_ms + 32'd30;
        send_tick(cur_ms);
    endtask

    task automatic test_coast_timing();
        send_clear();
        send_tick(cur_ms);
        send_tick(cur_ms + 32'd5999);
        send_tick(cur_ms + 32'd6000);
        // elapsed time across the 32 bit wrap
        cur_ms = 32'hFFFF_FF00;
        send_clear();
        send_box(1'b1, 12'd300, 12'd40, 12'd480);
        send_tick(cur_ms);
        send_clear();
        send_tick(cur_ms);
        send_tick(cur_ms + 32'h200);
        cur_ms = cur_ms + 32'd6000;
        send_tick(cur_ms);
        drain_results();
    endtask

    task automatic test_random_missions(input int n_items);
        int          sent;
        int          r;
        int          nb;
        int          ht;
        logic [11:0] img_w;
        logic [11:0] img_h;
        logic [11:0] h;
        logic [11:0] l;
        logic [11:0] w;
        logic [31:0] dt;
        sent = 0;
        while (sent < n_items)
        begin
            img_w = cfg_image_size[11:0];
            img_h = cfg_image_size[23:12];
            r = $urandom_range(99);
            case ($urandom_range(99) / 10)
                0, 1, 2, 3, 4: dt = $urandom_range(300);
                5, 6, 7:       dt = $urandom_range(int'(cfg_coast_ms));
                8:             dt = {16'd0, cfg_coast_ms} + $urandom_range(500);
                default:       dt = ($urandom_range(1) == 0) ? $urandom : $urandom_range(50);
            endcase
            if (r < 55)
            begin
                send_clear();
                nb = $urandom_range(3);
                for (int i = 0; i < nb; i++)
                begin
                    ht = (int'(cfg_commit) * int'(img_h)) / 32768;
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4: h = clamp_pix(ht + $urandom_range(40) - 20);
                        5, 6, 7:       h = 12'($urandom_range(int'(img_h)));
                        default:       h = 12'($urandom);
                    endcase
                    if ($urandom_range(9) < 7)
                    begin
                        l = 12'($urandom_range(int'(img_w)));
                        w = 12'($urandom_range(int'(img_w) - int'(l)));
                    end
                    else
                    begin
                        l = 12'($urandom);
                        w = 12'($urandom);
                    end
                    send_box($urandom_range(99) < 80, l, w, h);
                end
                cur_ms = cur_ms + dt;
                send_tick(cur_ms);
                sent += 2 + nb;
            end
            else if (r < 75)
            begin
                cur_ms = cur_ms + dt;
                send_tick(cur_ms);
                sent += 1;
            end
            else if (r < 88)
            begin
                send_clear();
                cur_ms = cur_ms + dt;
                send_tick(cur_ms);
                sent += 2;
            end
            else if (r < 95)
            begin
                send_transfer(random_item(spsq_pkg::KIND_BOX));
                sent += 1;
            end
            else
            begin
                send_transfer(random_item(KIND_SPARE));
                sent += 1;
            end
        end
        drain_results();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 8 == 0)
            begin
                send_clear();
                send_box(1'b1, 12'($urandom), 12'($urandom), 12'($urandom_range(200)));
            end
            cur_ms = cur_ms + $urandom_range(200);
            send_tick(cur_ms);
        end
        drain_results();
    endtask

    task automatic test_mission_finish();
        set_reg(spsq_pkg::REG_SETS_TO_PASS, {24'd0, sets_ahead(2)});
        run_pass();
        drain_results();
        set_reg(spsq_pkg::REG_SETS_TO_PASS, 32'd0);
        run_pass();
        for (int i = 0; i < 4; i++)
        begin
            cur_ms = cur_ms + 32'd50;
            send_tick(cur_ms);
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        cfg_image_size = '0;
        cfg_sets       = spsq_pkg::RST_SETS_TO_PASS;
        cfg_commit     = spsq_pkg::RST_COMMIT_FRACTION;
        cfg_coast_ms   = spsq_pkg::RST_COAST_TIME_MS;
        cfg_approach   = spsq_pkg::RST_APPROACH_THRUST;
        cfg_coast_thr  = spsq_pkg::RST_COAST_THRUST;
        cfg_gain       = spsq_pkg::RST_SWAY_GAIN_Q;
        cfg_side       = spsq_pkg::RST_SIDE_OFFSET;
        ms_seen        = 1'b0;
        ms_best_l      = '0;
        ms_best_w      = '0;
        ms_best_h      = '0;
        ms_committed   = 1'b0;
        ms_coasting    = 1'b0;
        ms_coast_t0    = '0;
        ms_sets_done   = '0;
        ms_finished    = 1'b0;
        cur_ms         = $urandom;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 6;
        recv_idle_pct = 88;
        test_hold_on_unknown_image();
        test_box_selection();
        test_coast_timing();

        write_settings({12'($urandom_range(480, 1)), 12'($urandom_range(640, 1))}, 8'd255,
                       16'd0, 16'd0, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h8000);
        test_random_missions(330);

        send_idle_pct = 88;
        recv_idle_pct = 6;
        write_settings(24'hFFFFFF, sets_ahead(100), 16'd32768, 16'hFFFF, 16'h8000, 16'h7FFF,
                       16'd0, 16'h7FFF);
        test_random_missions(330);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_settings({12'($urandom_range(4095, 1)), 12'($urandom_range(4095, 1))},
                       sets_ahead($urandom_range(100, 60)), 16'($urandom_range(32768)),
                       16'($urandom_range(3000)), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom));
        test_random_missions(330);

        test_output_backpressure();
        test_mission_finish();

        if (mismatch_count == 0 && pending_cmds.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
